FILE: hw/rtl/pli_pkg.sv
// ---------------------------------------------------------------------------
// pli_pkg : shared types and codes for the positional list
// Command, status and cell operation codes, word structs and list sizing.
// ---------------------------------------------------------------------------
package pli_pkg;

   localparam int CAPACITY = 16;
   localparam int LEN_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 8;
   localparam int VAL_W    = 32;

   typedef logic [LEN_W-1:0]        len_type;
   typedef logic [POS_W-1:0]        pos_type;
   typedef logic signed [VAL_W-1:0] val_type;

   localparam len_type LEN_MAX = len_type'(CAPACITY);

   // command codes
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   // status codes
   localparam logic [2:0] STAT_DONE  = 3'd0;
   localparam logic [2:0] STAT_FULL  = 3'd1;
   localparam logic [2:0] STAT_NODEL = 3'd2;
   localparam logic [2:0] STAT_EMPTY = 3'd3;
   localparam logic [2:0] STAT_ENTRY = 3'd4;

   typedef struct packed {
      logic [1:0] cmd;
      pos_type    position;
      val_type    item_value;
   } req_word_type;

   typedef struct packed {
      logic [2:0] status;
      val_type    entry_value;
      logic       last;
   } rsp_word_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      cell_op_type op;
      len_type     pos;
      len_type     wrap;
      val_type     item_value;
   } cell_ctl_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

FILE: hw/rtl/pli_cell.sv
// ---------------------------------------------------------------------------
// pli_cell : one list slot
// Holds one entry and moves it toward either neighbor on broadcast control.
// ---------------------------------------------------------------------------
module pli_cell (
   input  logic                  clock,
   input  pli_pkg::len_type      idx,
   input  pli_pkg::cell_ctl_type ctl,
   input  pli_pkg::val_type      left_val,
   input  pli_pkg::val_type      right_val,
   input  pli_pkg::val_type      head_val,
   output pli_pkg::val_type      val
);

   pli_pkg::val_type val_ff;
   pli_pkg::val_type val_in;

   always_comb begin
      val_in = val_ff;
      case (ctl.op)
         pli_pkg::CELL_INSERT: begin
            // open a gap at pos, push the tail right
            if (idx == ctl.pos) begin
               val_in = ctl.item_value;
            end else if (idx > ctl.pos) begin
               val_in = left_val;
            end
         end
         pli_pkg::CELL_DELETE: begin
            // close the gap at pos, pull the tail left
            if (idx >= ctl.pos) begin
               val_in = right_val;
            end
         end
         pli_pkg::CELL_ROTATE: begin
            // the back entry takes the head, all others advance
            if (idx == ctl.wrap) begin
               val_in = head_val;
            end else begin
               val_in = right_val;
            end
         end
         default: begin
            val_in = val_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val = val_ff;

endmodule

FILE: hw/rtl/positional_list_insert_delete_top.sv
// ---------------------------------------------------------------------------
// positional_list_insert_delete_top : ordered list with positional edits
// Insert, delete and full readout over a chain of value cells.
// ---------------------------------------------------------------------------
//
//   channel   direction  ports                            word
//   request   in         req_valid, req_stall, req_word   cmd, position, item_value
//   response  out        rsp_valid, rsp_stall, rsp_word   status, entry_value, last
//
// Insert and delete shift every cell in parallel as the request is taken
// and register one response word. A readout takes the request first, then
// sends one response word per entry, front to back; the cell chain
// rotates by one per word sent, so the list is back in order after the last
// word. Requests stall during a readout and while a response word waits
// under rsp_stall. Reset empties the list; the cell contents themselves are
// not cleared.
// ---------------------------------------------------------------------------
module positional_list_insert_delete_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pli_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pli_pkg::rsp_word_type rsp_word
);

   pli_pkg::state_type    state_ff;
   pli_pkg::state_type    state_in;
   pli_pkg::len_type      len_ff;
   pli_pkg::len_type      len_in;
   pli_pkg::len_type      cnt_ff;
   pli_pkg::len_type      cnt_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   pli_pkg::rsp_word_type rsp_word_ff;
   pli_pkg::rsp_word_type rsp_next;
   logic                  rsp_load;
   pli_pkg::cell_ctl_type ctl;
   pli_pkg::val_type      cell_val [pli_pkg::CAPACITY];
   pli_pkg::len_type      pos_clamp;
   pli_pkg::len_type      len_last;
   logic                  out_free;
   logic                  req_acc;
   logic                  read_end;

   // ---- handshake ----------------------------------------------------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != pli_pkg::ST_IDLE) || !out_free;
   assign req_acc   = req_valid && !req_stall;

   // position at or past the length means the back of the list
   assign pos_clamp = (req_word.position >= pli_pkg::pos_type'(len_ff)) ?
                      len_ff : pli_pkg::len_type'(req_word.position);
   assign len_last  = len_ff - 1'b1;
   assign read_end  = (cnt_ff == len_last);

   // ---- cell chain ---------------------------------------------------------
   for (genvar i = 0; i < pli_pkg::CAPACITY; i++) begin : g_cell
      pli_pkg::val_type left_val;
      pli_pkg::val_type right_val;
      if (i == 0) begin : g_front
         assign left_val = cell_val[0];
      end else begin : g_mid_l
         assign left_val = cell_val[i-1];
      end
      if (i == pli_pkg::CAPACITY - 1) begin : g_back
         assign right_val = cell_val[i];
      end else begin : g_mid_r
         assign right_val = cell_val[i+1];
      end
      pli_cell u_cell (
         .clock     (clock),
         .idx       (pli_pkg::len_type'(i)),
         .ctl       (ctl),
         .left_val  (left_val),
         .right_val (right_val),
         .head_val  (cell_val[0]),
         .val       (cell_val[i])
      );
   end

   // ---- next state ---------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pli_pkg::ST_IDLE: begin
            if (req_acc && (req_word.cmd == pli_pkg::CMD_READ) && (len_ff != '0)) begin
               state_in = pli_pkg::ST_READ;
            end
         end
         pli_pkg::ST_READ: begin
            if (out_free && read_end) begin
               state_in = pli_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pli_pkg::ST_IDLE;
         end
      endcase
   end

   // ---- sequencer outputs --------------------------------------------------
   always_comb begin
      ctl.op         = pli_pkg::CELL_HOLD;
      ctl.pos        = pos_clamp;
      ctl.wrap       = len_last;
      ctl.item_value = req_word.item_value;
      len_in         = len_ff;
      cnt_in         = cnt_ff;
      rsp_load       = 1'b0;
      rsp_next       = '{status: pli_pkg::STAT_DONE, entry_value: '0, last: 1'b1};
      case (state_ff)
         pli_pkg::ST_IDLE: begin
            if (req_acc) begin
               case (req_word.cmd)
                  pli_pkg::CMD_INSERT: begin
                     rsp_load = 1'b1;
                     if (len_ff == pli_pkg::LEN_MAX) begin
                        rsp_next.status = pli_pkg::STAT_FULL;
                     end else begin
                        ctl.op = pli_pkg::CELL_INSERT;
                        len_in = len_ff + 1'b1;
                     end
                  end
                  pli_pkg::CMD_DELETE: begin
                     rsp_load = 1'b1;
                     if (req_word.position >= pli_pkg::pos_type'(len_ff)) begin
                        rsp_next.status = pli_pkg::STAT_NODEL;
                     end else begin
                        ctl.op = pli_pkg::CELL_DELETE;
                        len_in = len_last;
                     end
                  end
                  pli_pkg::CMD_READ: begin
                     cnt_in = '0;
                     if (len_ff == '0) begin
                        rsp_load        = 1'b1;
                        rsp_next.status = pli_pkg::STAT_EMPTY;
                     end
                  end
                  default: begin
                     // unused command: drop the word
                     rsp_load = 1'b0;
                  end
               endcase
            end
         end
         pli_pkg::ST_READ: begin
            // send the head, rotate the chain by one
            if (out_free) begin
               rsp_load             = 1'b1;
               rsp_next.status      = pli_pkg::STAT_ENTRY;
               rsp_next.entry_value = cell_val[0];
               rsp_next.last        = read_end;
               ctl.op               = pli_pkg::CELL_ROTATE;
               cnt_in               = cnt_ff + 1'b1;
            end
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   // ---- response register --------------------------------------------------
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pli_pkg::ST_IDLE;
         len_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_word_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---- assertions ---------------------------------------------------------
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= pli_pkg::LEN_MAX)
      else $error("list length above capacity");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pli_pkg::ST_READ) |-> (cnt_ff < len_ff))
      else $error("readout count past list length");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_word.cmd == pli_pkg::CMD_INSERT) && (len_ff == pli_pkg::LEN_MAX))
      |=> (rsp_valid && (rsp_word.status == pli_pkg::STAT_FULL) && $stable(len_ff)))
      else $error("insert into full list not rejected");

   a_edit_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_acc && ((req_word.cmd == pli_pkg::CMD_INSERT) ||
                   (req_word.cmd == pli_pkg::CMD_DELETE)))
      |=> (rsp_valid && rsp_word.last))
      else $error("edit gave no final response word");

endmodule

FILE: tb/positional_list_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// positional_list_checker : response predictor and scoreboard
// Watches both channels of the positional list, keeps its own copy of the
// list, queues the response words each request should give and compares
// every accepted response word against the oldest one due.
// ---------------------------------------------------------------------------
module positional_list_checker
   import pli_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_word,
   output int           mismatch_count,
   output int           due_count,
   output int           words_checked,
   output int           full_rejects,
   output int           empty_deletes,
   output int           peak_len
);

   val_type      list_vals [CAPACITY];
   int           list_len;
   rsp_word_type due_words [$];

   // Apply one request to the local list and queue the words it must give.
   task automatic apply_list_request(input req_word_type w);
      rsp_word_type r;
      int           slot;
      int           i;
      r = '0;
      r.last = 1'b1;
      case (w.cmd)
         CMD_INSERT: begin
            if (list_len >= CAPACITY) begin
               r.status = STAT_FULL;
               full_rejects++;
            end else begin
               slot = (int'(w.position) > list_len) ? list_len : int'(w.position);
               for (i = list_len; i > slot; i--)
                  list_vals[i] = list_vals[i-1];
               list_vals[slot] = w.item_value;
               list_len++;
               if (list_len > peak_len)
                  peak_len = list_len;
               r.status = STAT_DONE;
            end
            due_words.push_back(r);
         end
         CMD_DELETE: begin
            if (int'(w.position) >= list_len) begin
               r.status = STAT_NODEL;
               empty_deletes++;
            end else begin
               for (i = int'(w.position); i + 1 < list_len; i++)
                  list_vals[i] = list_vals[i+1];
               list_len--;
               r.status = STAT_DONE;
            end
            due_words.push_back(r);
         end
         CMD_READ: begin
            if (list_len == 0) begin
               r.status = STAT_EMPTY;
               due_words.push_back(r);
            end else begin
               for (i = 0; i < list_len; i++) begin
                  r.status      = STAT_ENTRY;
                  r.entry_value = list_vals[i];
                  r.last        = (i == list_len - 1);
                  due_words.push_back(r);
               end
            end
         end
         default: ;  // unused code: no word, no change
      endcase
   endtask

   task automatic check_list_word(input rsp_word_type got);
      rsp_word_type want;
      if (due_words.size() == 0) begin
         $display("%0t: unexpected response word: status %0d value %0d last %0b",
                  $time, got.status, got.entry_value, got.last);
         mismatch_count++;
      end else begin
         want = due_words.pop_front();
         words_checked++;
         if (got.status !== want.status) begin
            $display("%0t: status: expected %0d, actual %0d",
                     $time, want.status, got.status);
            mismatch_count++;
         end
         if (got.entry_value !== want.entry_value) begin
            $display("%0t: entry_value: expected %0d, actual %0d",
                     $time, want.entry_value, got.entry_value);
            mismatch_count++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last: expected %0b, actual %0b",
                     $time, want.last, got.last);
            mismatch_count++;
         end
      end
   endtask

   // Responses are registered, so a word accepted at this edge never belongs
   // to a request accepted at the same edge: check first, then predict.
   always @(posedge clock) begin
      if (reset) begin
         list_len = 0;
         due_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            check_list_word(rsp_word);
         if (req_valid && !req_stall)
            apply_list_request(req_word);
      end
      due_count = due_words.size();
   end

endmodule

FILE: tb/tb_positional_list_insert_delete_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_positional_list_insert_delete_top : positional list testbench
// Drives directed and random insert, delete and readout requests in bursts
// against a stalling receiver; the checker predicts and scores every word.
// ---------------------------------------------------------------------------
module tb_positional_list_insert_delete_top;
   import pli_pkg::*;

   // code with no defined meaning; the block must swallow it silently
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 200;

   logic         clock     = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   int mismatch_count;
   int due_count;
   int words_checked;
   int full_rejects;
   int empty_deletes;
   int peak_len;

   int requests_sent = 0;
   int cycle_count   = 0;

   // 10 ns clock
   always #5 clock = ~clock;

   positional_list_insert_delete_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   positional_list_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word),
      .mismatch_count (mismatch_count),
      .due_count      (due_count),
      .words_checked  (words_checked),
      .full_rejects   (full_rejects),
      .empty_deletes  (empty_deletes),
      .peak_len       (peak_len)
   );

   // Receiver back-pressure. Rotate through four moods in turn so stalls
   // land on every part of a readout: free flow, light random stall, heavy
   // random stall and a fixed two-in-five pattern.
   always @(negedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         case ((cycle_count / 97) % 4)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ((cycle_count % 5) < 2);
         endcase
      end
   end

   // Hard stop in case the block hangs or a response never shows up.
   // Worst case is far below this: ~230 requests, up to 16 words each,
   // each word held up by heavy stall.
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Present one request word at the falling edge and hold it until the
   // block takes it. Leave valid high when the burst goes on, so that it
   // never drops and rises within one step; drop it for the gap otherwise.
   task automatic send_word(input logic [1:0] cmd, input int position,
                            input logic [31:0] value, input int gap_after);
      req_word.cmd        = cmd;
      req_word.position   = pos_type'(position);
      req_word.item_value = val_type'(value);
      req_valid           = 1'b1;
      do
         @(posedge clock);
      while (req_stall);
      requests_sent++;
      @(negedge clock);
      if (gap_after > 0) begin
         req_valid = 1'b0;
         repeat (gap_after) @(negedge clock);
      end
   endtask

   // Pause the sender until every due response word has come back.
   task automatic hold_until_drained();
      req_valid = 1'b0;
      @(negedge clock);
      while (due_count != 0)
         @(negedge clock);
   endtask

   // Positions: mostly around the live range, sometimes far past capacity.
   function automatic int pick_position();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 3);
         3:       return $urandom_range(0, 255);
         default: return $urandom_range(0, CAPACITY + 1);
      endcase
   endfunction

   // Values: lean on the signed extremes now and then.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return ($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 32'h0;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int         random_sent;
      int         burst_left;
      int         gap_len;
      int         roll;
      int         k;
      logic [1:0] cmd;
      logic       drained_mid;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_word    = '0;
      random_sent = 0;
      burst_left  = 0;
      gap_len     = 0;
      drained_mid = 1'b0;

      // synchronous reset, released on a falling edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed part ----
      // empty list: readout gives the empty status, deletes find nothing
      send_word(CMD_READ,   0,   32'h0, $urandom_range(0, 2));
      send_word(CMD_DELETE, 0,   32'h0, 0);
      send_word(CMD_DELETE, 255, 32'h0, $urandom_range(0, 2));
      // build a short list: append on empty, front, middle, append at length
      send_word(CMD_INSERT, 255, 32'h8000_0000, 0);
      send_word(CMD_INSERT, 0,   32'h7fff_ffff, 0);
      send_word(CMD_INSERT, 1,   32'hffff_ffff, $urandom_range(0, 3));
      send_word(CMD_INSERT, 3,   32'h0000_0000, 0);
      send_word(CMD_READ,   0,   32'h0, 0);
      // delete back, front, then one at the length (nothing to delete)
      send_word(CMD_DELETE, 3,   32'h0, 0);
      send_word(CMD_DELETE, 0,   32'h0, $urandom_range(0, 3));
      send_word(CMD_DELETE, 2,   32'h0, 0);
      // unused code: no word should come back
      send_word(CMD_UNUSED, 7,   32'h5a5a_a5a5, 0);
      // fill to capacity from two entries
      for (k = 0; k < CAPACITY - 2; k++)
         send_word(CMD_INSERT, (k % 3 == 0) ? 255 : k, $urandom,
                   (k % 4 == 3) ? $urandom_range(1, 4) : 0);
      // full list: insert is rejected, readout gives every entry
      send_word(CMD_INSERT, 5,  32'h1234_5678, 0);
      send_word(CMD_READ,   0,  32'h0, 0);
      send_word(CMD_DELETE, CAPACITY - 1, 32'h0, 0);

      // let the list settle before the random part
      hold_until_drained();

      // ---- random part ----
      // Alternate growing and shrinking phases so the list swings between
      // empty and full, with readouts sprinkled throughout.
      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent == RANDOM_ITEMS / 2 && !drained_mid) begin
            hold_until_drained();
            drained_mid = 1'b1;
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end
         roll = $urandom_range(0, 99);
         if (((random_sent / 40) % 2) == 0)
            cmd = (roll < 65) ? CMD_INSERT : (roll < 85) ? CMD_DELETE :
                  (roll < 96) ? CMD_READ : CMD_UNUSED;
         else
            cmd = (roll < 20) ? CMD_INSERT : (roll < 80) ? CMD_DELETE :
                  (roll < 96) ? CMD_READ : CMD_UNUSED;
         burst_left--;
         send_word(cmd, pick_position(), pick_value(),
                   (burst_left == 0) ? gap_len : 0);
         // ignored codes do not count toward the random total
         if (cmd != CMD_UNUSED)
            random_sent++;
      end

      // ---- wrap-up ----
      // wait out every due word, then idle on to catch anything stray
      hold_until_drained();
      repeat (20) @(negedge clock);

      $display("Covered %0d requests (%0d random), %0d response words checked, list length peaked at %0d.",
               requests_sent, random_sent, words_checked, peak_len);
      $display("Saw %0d full-list rejects and %0d deletes with nothing to remove.",
               full_rejects, empty_deletes);
      if (mismatch_count == 0 && due_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/pli_pkg.sv
hw/rtl/pli_cell.sv
hw/rtl/positional_list_insert_delete_top.sv
tb/positional_list_checker.sv
tb/tb_positional_list_insert_delete_top.sv
